// ===== rtl/core/ms_pkg.sv =====
// Shared types and constants for the merge sorter.
package ms_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

// ===== rtl/core/ms_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
module ms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/merge_sorter.sv =====
// Merge sorter top level: list load, bottom-up merge passes over two RAMs, sorted emit.
//
// A list of signed 32-bit values is loaded one transaction per cycle into
// buffer A, the final transaction marked by last; transactions beyond
// MAX_ELEMENTS are dropped and reported on overflowed with every result of
// that list. After the last transaction the block stops taking input and
// sorts with bottom-up merge passes that ping-pong between buffer A and
// buffer B (ties go to the left run, so the sort is stable), then emits the
// sorted values in ascending order with last_out on the final one. A list of
// n elements takes ceil(log2 n) passes; in each pass every run pair is set up
// and both run heads are read, then for each element a refilled head is
// captured and one element is written, and the pass is closed. Every element
// goes through the single registered read port of the source buffer before it
// is compared and written. Results then leave at one per cycle while the
// consumer keeps result_ready high. Input is taken again as soon as the final
// result sits in the output register. The buffers need no clearing after
// reset: only entries written for the current list are read.
module merge_sorter #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    // input item channel
    input  logic                item_valid,
    output logic                item_ready,
    input  ms_pkg::data_t       value,
    input  logic                last,
    // result channel
    output logic                result_valid,
    input  logic                result_ready,
    output ms_pkg::data_t       sorted_value,
    output logic                last_out,
    output logic                overflowed
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);

    // sequencer states
    localparam logic [2:0] ST_LOAD  = 3'd0;  // taking list transactions
    localparam logic [2:0] ST_PAIR  = 3'd1;  // set up next run pair or close pass
    localparam logic [2:0] ST_FA    = 3'd2;  // read left run head
    localparam logic [2:0] ST_FB    = 3'd3;  // capture left head, read right head
    localparam logic [2:0] ST_CAP   = 3'd4;  // capture refilled head
    localparam logic [2:0] ST_MERGE = 3'd5;  // compare heads, write one element
    localparam logic [2:0] ST_EMRD  = 3'd6;  // read first sorted element
    localparam logic [2:0] ST_EMIT  = 3'd7;  // stream sorted elements out

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;      // elements stored for this list
    logic          ovf_reg, ovf_next;          // a transaction was dropped
    logic [CW-1:0] n_reg, n_next;              // list length being sorted
    logic [CW:0]   width_reg, width_next;      // run width of current pass
    logic          src_sel_reg, src_sel_next;  // 0: A is source, 1: B is source
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] a_reg, a_next;              // left run read pointer
    logic [CW-1:0] b_reg, b_next;              // right run read pointer
    logic [CW-1:0] k_reg, k_next;              // write pointer / emit index
    logic          cap_b_reg, cap_b_next;      // refill goes to right head
    ms_pkg::data_t va_reg, va_next;            // left run head
    ms_pkg::data_t vb_reg, vb_next;            // right run head

    // output register
    logic          rv_reg, rv_next;
    ms_pkg::data_t out_val_reg, out_val_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    // memory side
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic          wr_load;
    logic          wr_merge;
    ms_pkg::data_t merge_data;
    ms_pkg::data_t rd_a, rd_b, rd_src;
    logic          ram_a_we, ram_b_we;
    logic [AW-1:0] ram_a_waddr;
    ms_pkg::data_t ram_a_wdata;

    // merge datapath
    logic          a_left, b_left, take_a;
    logic          item_acc;
    logic          has_room;
    logic [CW-1:0] count_inc;
    logic [CW+1:0] sum_mid, sum_hi, n_ext;
    logic [CW:0]   width_dbl;
    logic          load_out;

    assign item_ready = (state_reg == ST_LOAD);
    assign item_acc   = item_valid && item_ready;
    assign has_room   = (count_reg < CNT_MAX);
    assign count_inc  = has_room ? (count_reg + CNT_ONE) : count_reg;

    assign a_left     = (a_reg < mid_reg);
    assign b_left     = (b_reg < hi_reg);
    assign take_a     = a_left && (!b_left || (va_reg <= vb_reg));
    assign merge_data = take_a ? va_reg : vb_reg;

    assign sum_mid   = {2'b00, lo_reg} + {1'b0, width_reg};
    assign sum_hi    = {2'b00, lo_reg} + {width_reg, 1'b0};
    assign n_ext     = {2'b00, n_reg};
    assign width_dbl = {width_reg[CW-1:0], 1'b0};

    assign load_out  = (state_reg == ST_EMIT) && (!rv_reg || result_ready);

    assign rd_src = src_sel_reg ? rd_b : rd_a;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        n_next       = n_reg;
        width_next   = width_reg;
        src_sel_next = src_sel_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        cap_b_next   = cap_b_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        rd_en        = 1'b0;
        rd_addr      = a_reg;
        wr_load      = 1'b0;
        wr_merge     = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_acc)
                begin
                    wr_load    = has_room;
                    count_next = count_inc;
                    if (!has_room)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        n_next       = count_inc;
                        width_next   = (CW+1)'(1);
                        lo_next      = '0;
                        src_sel_next = 1'b0;
                        state_next   = (count_inc == CNT_ONE) ? ST_EMRD : ST_PAIR;
                    end
                end
            end
            ST_PAIR:
            begin
                if (lo_reg >= n_reg)
                begin
                    // pass done: the written buffer becomes the source
                    src_sel_next = !src_sel_reg;
                    width_next   = width_dbl;
                    lo_next      = '0;
                    if (width_dbl >= {1'b0, n_reg})
                    begin
                        state_next = ST_EMRD;
                    end
                end
                else
                begin
                    mid_next   = (sum_mid > n_ext) ? n_reg : sum_mid[CW-1:0];
                    hi_next    = (sum_hi > n_ext) ? n_reg : sum_hi[CW-1:0];
                    a_next     = lo_reg;
                    b_next     = (sum_mid > n_ext) ? n_reg : sum_mid[CW-1:0];
                    k_next     = lo_reg;
                    state_next = ST_FA;
                end
            end
            ST_FA:
            begin
                rd_en      = 1'b1;
                rd_addr    = a_reg;
                state_next = ST_FB;
            end
            ST_FB:
            begin
                va_next    = rd_src;
                rd_en      = b_left;
                rd_addr    = b_reg;
                cap_b_next = 1'b1;
                state_next = ST_CAP;
            end
            ST_CAP:
            begin
                if (cap_b_reg)
                begin
                    vb_next = rd_src;
                end
                else
                begin
                    va_next = rd_src;
                end
                state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                wr_merge = 1'b1;
                k_next   = k_reg + CNT_ONE;
                if (take_a)
                begin
                    a_next     = a_reg + CNT_ONE;
                    rd_addr    = a_reg + CNT_ONE;
                    rd_en      = ((a_reg + CNT_ONE) < mid_reg);
                    cap_b_next = 1'b0;
                end
                else
                begin
                    b_next     = b_reg + CNT_ONE;
                    rd_addr    = b_reg + CNT_ONE;
                    rd_en      = ((b_reg + CNT_ONE) < hi_reg);
                    cap_b_next = 1'b1;
                end
                if ((k_reg + CNT_ONE) == hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = ST_PAIR;
                end
                else
                begin
                    state_next = ST_CAP;
                end
            end
            ST_EMRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                k_next     = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    if ((k_reg + CNT_ONE) == n_reg)
                    begin
                        // final result registered; next list may start loading
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next  = k_reg + CNT_ONE;
                        rd_en   = 1'b1;
                        rd_addr = k_reg + CNT_ONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // output register: while emitting, refilled whenever it is empty or being drained
    always_comb
    begin
        rv_next       = rv_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        out_ovf_next  = out_ovf_reg;
        if (load_out)
        begin
            rv_next       = 1'b1;
            out_val_next  = rd_src;
            out_last_next = ((k_reg + CNT_ONE) == n_reg);
            out_ovf_next  = ovf_reg;
        end
        else if (result_ready)
        begin
            rv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            rv_reg      <= 1'b0;
            src_sel_reg <= 1'b0;
            cap_b_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            rv_reg      <= rv_next;
            src_sel_reg <= src_sel_next;
            cap_b_reg   <= cap_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        width_reg    <= width_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // A takes the load stream and results of passes that read B; B takes results of passes that read A
    assign ram_a_we    = wr_load || (wr_merge && src_sel_reg);
    assign ram_a_waddr = wr_load ? count_reg[AW-1:0] : k_reg[AW-1:0];
    assign ram_a_wdata = wr_load ? value : merge_data;
    assign ram_b_we    = wr_merge && !src_sel_reg;

    ms_ram #(
        .WIDTH (ms_pkg::DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_buf_a (
        .clk   (clk),
        .we    (ram_a_we),
        .waddr (ram_a_waddr),
        .wdata (ram_a_wdata),
        .re    (rd_en && !src_sel_reg),
        .raddr (rd_addr[AW-1:0]),
        .rdata (rd_a)
    );

    ms_ram #(
        .WIDTH (ms_pkg::DATA_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_buf_b (
        .clk   (clk),
        .we    (ram_b_we),
        .waddr (k_reg[AW-1:0]),
        .wdata (merge_data),
        .re    (rd_en && src_sel_reg),
        .raddr (rd_addr[AW-1:0]),
        .rdata (rd_b)
    );

    assign result_valid = rv_reg;
    assign sorted_value = out_val_reg;
    assign last_out     = out_last_reg;
    assign overflowed   = out_ovf_reg;

`ifndef SYNTHESIS
    // store never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("element count beyond capacity");

    // a merge step always has an element left to take, inside its run pair
    a_merge_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> ((a_left || b_left) && (k_reg < hi_reg)))
        else $error("merge step with both runs exhausted");

    // emit index stays inside the sorted list
    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (k_reg < n_reg))
        else $error("emit index past list length");

    // a final result is always followed by a return to loading
    a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && ((k_reg + CNT_ONE) == n_reg)) |=> (state_reg == ST_LOAD))
        else $error("no return to load after final result");
`endif

endmodule

// ===== tb/sv/merge_sorter_checker.sv =====
// Result checker for the merge sorter: tracks lists on the input channel and checks sorted output.
`timescale 1ns / 100ps

module merge_sorter_checker #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  logic          item_ready,
    input  ms_pkg::data_t value,
    input  logic          last,
    input  logic          result_valid,
    input  logic          result_ready,
    input  ms_pkg::data_t sorted_value,
    input  logic          last_out,
    input  logic          overflowed,
    output int            mismatch_count,
    output int            results_pending
);

    typedef struct packed {
        ms_pkg::data_t element;
        logic          final_one;
        logic          dropped;
    } sorted_entry_t;

    ms_pkg::data_t list_in_progress[$];
    logic          list_dropped;
    sorted_entry_t sorted_expect[$];
    int            mismatches;

    // ascending order, equal values keep arrival order
    task automatic queue_sorted_list();
        ms_pkg::data_t held;
        int            pos;
        for (int i = 1; i < list_in_progress.size(); i++)
        begin
            pos = i;
            while (pos > 0 && list_in_progress[pos-1] > list_in_progress[pos])
            begin
                held = list_in_progress[pos-1];
                list_in_progress[pos-1] = list_in_progress[pos];
                list_in_progress[pos] = held;
                pos--;
            end
        end
        for (int k = 0; k < list_in_progress.size(); k++)
            sorted_expect.push_back('{list_in_progress[k],
                                      k == list_in_progress.size() - 1, list_dropped});
        list_in_progress.delete();
        list_dropped = 1'b0;
    endtask

    task automatic take_item();
        if (list_in_progress.size() < MAX_ELEMENTS)
            list_in_progress.push_back(value);
        else
            list_dropped = 1'b1;
        if (last)
            queue_sorted_list();
    endtask

    task automatic report(string field, longint expected, longint actual);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, field, expected, actual);
    endtask

    task automatic check_result();
        sorted_entry_t exp_entry;
        if (sorted_expect.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %0d last %0b ovf %0b",
                     $time, sorted_value, last_out, overflowed);
        end
        else
        begin
            exp_entry = sorted_expect.pop_front();
            if (sorted_value !== exp_entry.element)
                report("sorted_value", exp_entry.element, sorted_value);
            if (last_out !== exp_entry.final_one)
                report("last_out", exp_entry.final_one, last_out);
            if (overflowed !== exp_entry.dropped)
                report("overflowed", exp_entry.dropped, overflowed);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_in_progress.delete();
            sorted_expect.delete();
            list_dropped = 1'b0;
            mismatches = 0;
            mismatch_count <= 0;
            results_pending <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_result();
            if (item_valid && item_ready)
                take_item();
            mismatch_count <= mismatches;
            results_pending <= sorted_expect.size();
        end
    end

endmodule

// ===== tb/sv/merge_sorter_tb.sv =====
// Top-level testbench for the merge sorter: list stimulus, result back-pressure and verdict.
`timescale 1ns / 100ps

module merge_sorter_tb;

    localparam int MAX_ELEMENTS = 64;
    // Longest correct stretch without any transaction is one full-size sort
    // plus the long hold-off; this is well above.
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 160;
    localparam int HOLD_OFF_AT  = 40;   // result count at which the receiver backs off
    localparam int HOLD_OFF_LEN = 300;
    localparam int DRAIN_CYCLES = 64;
    localparam int DIRECTED_N   = 21;

    localparam ms_pkg::data_t MOST_NEG = 32'sh8000_0000;
    localparam ms_pkg::data_t MOST_POS = 32'sh7FFF_FFFF;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_ready;
    ms_pkg::data_t value;
    logic          last;
    logic          result_valid;
    logic          result_ready;
    ms_pkg::data_t sorted_value;
    logic          last_out;
    logic          overflowed;

    int    mismatch_count;
    int    results_pending;
    int    stall_cycles;
    int    results_taken;
    bit    sender_burst;
    bit    receiver_burst;

    // Directed lists, each closed by a set end flag:
    //   single most negative, single most positive, a reversed pair of the
    //   extremes, a list full of ties, alternating bit patterns with repeated
    //   extremes, an already sorted list and a reversed one.
    ms_pkg::data_t directed_vals[DIRECTED_N] = '{
        MOST_NEG,
        MOST_POS,
        MOST_POS, MOST_NEG,
        32'sd0, -32'sd1, 32'sd0, 32'sd1, -32'sd1,
        MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, 32'sh5555_5555, 32'shAAAA_AAAA,
        32'sd1, 32'sd2, 32'sd3,
        32'sd3, 32'sd2, 32'sd1
    };
    bit directed_ends[DIRECTED_N] = '{
        1,
        1,
        0, 1,
        0, 0, 0, 0, 1,
        0, 0, 0, 0, 0, 1,
        0, 0, 1,
        0, 0, 1
    };

    merge_sorter #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflowed   (overflowed)
    );

    merge_sorter_checker #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .value           (value),
        .last            (last),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .sorted_value    (sorted_value),
        .last_out        (last_out),
        .overflowed      (overflowed),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one input transaction. The gap before it is drawn per item; valid
    // is only lowered when there is a gap, so back-to-back items never see a
    // low-then-high pair of assignments in the same time step. Returns at the
    // edge where the transaction is accepted.
    task automatic send_item(ms_pkg::data_t v, bit is_last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        value      <= v;
        last       <= is_last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // Value mixes: full-range random, a narrow band around zero so ties are
    // common, and the extremes of the signed range together with -1 and 0.
    function automatic ms_pkg::data_t pick_value(int mix);
        case (mix)
            1: return ms_pkg::data_t'(int'($urandom_range(0, 6)) - 3);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return -32'sd1;
                    default: return 32'sd0;
                endcase
            end
            default: return ms_pkg::data_t'($urandom);
        endcase
    endfunction

    // Stimulus: directed lists, then random lists. Most random lists are
    // short; one fills the store exactly and one runs two items past it, so
    // both an ordinary item and the end-of-list item are dropped.
    initial
    begin : stimulus
        int list_no;
        int list_len;
        int mix;
        int items_sent;

        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        value        <= '0;
        last         <= 1'b0;
        sender_burst = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_item(directed_vals[i], directed_ends[i]);

        list_no    = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (list_no == 2)
                list_len = MAX_ELEMENTS;
            else if (list_no == 6)
                list_len = MAX_ELEMENTS + 2;
            else
                list_len = $urandom_range(1, 12);
            sender_burst = ($urandom_range(0, 3) == 0);
            mix = $urandom_range(0, 3);
            for (int i = 0; i < list_len; i++)
                send_item(pick_value(mix), i == list_len - 1);
            items_sent += list_len;
            list_no++;
        end
        item_valid <= 1'b0;

        // One edge so the checker has seen the final transaction, then drain.
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side: random ready gaps per transaction, with occasional bursts
    // of constant ready, and one long hold-off while lists keep arriving so
    // the sorter backs up and stalls the input channel.
    initial
    begin : receiver
        int gap;

        result_ready   <= 1'b0;
        results_taken  = 0;
        receiver_burst = 1'b0;
        @(posedge clk);
        forever
        begin
            gap = receiver_burst ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!(rst_n && result_valid))
                @(posedge clk);
            results_taken++;
            if (results_taken % 16 == 0)
                receiver_burst = ($urandom_range(0, 3) == 0);
            if (results_taken == HOLD_OFF_AT)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/core/ms_pkg.sv
rtl/core/ms_ram.sv
rtl/core/merge_sorter.sv
tb/sv/merge_sorter_checker.sv
tb/sv/merge_sorter_tb.sv
